### sv/tpu_pkg.sv
// Shared types, codes and constant functions of the turtle pose update unit.
package tpu_pkg;

  // Command codes carried in the low bits of the input tuser.
  typedef enum logic [2:0] {
    OP_TURN    = 3'd0,
    OP_PITCH   = 3'd1,
    OP_MOVE    = 3'd2,
    OP_SET_POS = 3'd3,
    OP_SET_COL = 3'd4,
    OP_REPORT  = 3'd5
  } tpu_op_t;

  // One command as it travels through the front part and the queue.
  typedef struct packed {
    logic [31:0] value_z;
    logic [31:0] value_y;
    logic [31:0] value_x;
    logic [31:0] distance;
    logic [15:0] angle_degrees;
    logic [1:0]  column_select;
    logic [2:0]  opcode;
  } tpu_item_t;

  localparam int IN_DATA_W = 144;
  localparam int IN_USER_W = 5;
  localparam int OUT_DATA_W = 240;

  // Number of orientation columns; a column select at or above this is ignored.
  localparam logic [1:0] NUM_COLS = 2'd3;

  // Angle reduction: bias by a multiple of 360 above 2^15, then a reciprocal
  // multiply that gives the exact floor quotient for every biased value.
  localparam int ANGLE_BIAS = 33120;
  localparam int RECIP_360 = 93207;
  localparam int RECIP_SHIFT = 25;
  localparam int DEG_QUARTER = 90;
  localparam int DEG_HALF = 180;
  localparam int DEG_3QUARTER = 270;
  localparam int DEG_FULL = 360;

  // One degree in radians, Q2.30.
  localparam logic [63:0] DEG_Q30 = 64'd18740330;

  // Quarter-wave sine entry round(sin(k deg) * 2^frac) from a fixed-point
  // Taylor series; evaluated at elaboration only.
  function automatic logic [31:0] sin_rom(input int k, input int frac);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic signed [64:0] s;
    int n;
    x = 64'(k) * DEG_Q30;
    x2 = (x * x) >> 30;
    term = x;
    s = $signed({1'b0, x});
    term = ((term * x2) >> 30) / 64'd6;
    s = s - $signed({1'b0, term});
    term = ((term * x2) >> 30) / 64'd20;
    s = s + $signed({1'b0, term});
    term = ((term * x2) >> 30) / 64'd42;
    s = s - $signed({1'b0, term});
    term = ((term * x2) >> 30) / 64'd72;
    s = s + $signed({1'b0, term});
    term = ((term * x2) >> 30) / 64'd110;
    s = s - $signed({1'b0, term});
    term = ((term * x2) >> 30) / 64'd156;
    s = s + $signed({1'b0, term});
    if (s < 0) begin
      s = '0;
    end
    n = 30 - frac;
    if (n > 0) begin
      s = (s + (65'sd1 <<< (n - 1))) >>> n;
    end
    return 32'(s);
  endfunction

endpackage

### sv/tpu_front.sv
// Front part: accepts commands, reduces the angle and looks up sine and cosine.
module tpu_front #(
  parameter int ORIENT_WIDTH = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  tpu_pkg::tpu_item_t               in_item,
  input  logic                             q_full,
  output logic                             push,
  output tpu_pkg::tpu_item_t               push_item,
  output logic signed [ORIENT_WIDTH-1:0]   push_sin,
  output logic signed [ORIENT_WIDTH-1:0]   push_cos
);

  localparam int FRAC = ORIENT_WIDTH - 2;

  logic advance;
  logic v1_r, v2_r, v3_r;
  tpu_pkg::tpu_item_t item1_r, item2_r, item3_r;
  logic [16:0] u_nxt, u1_r;
  logic [33:0] quot_prod;
  logic [7:0] q1_r;
  logic [16:0] a_full;
  logic [8:0] a2_r;
  logic [9:0] b_sum;
  logic [8:0] b_ang;
  logic [7:0] fold_s, fold_c;
  logic signed [ORIENT_WIDTH-1:0] rom_q [0:90];
  logic signed [ORIENT_WIDTH-1:0] sin_nxt, cos_nxt, sin3_r, cos3_r;

  // Constant quarter-wave table.
  for (genvar k = 0; k <= 90; k++) begin : g_rom
    localparam logic [31:0] ROM_V = tpu_pkg::sin_rom(k, FRAC);
    assign rom_q[k] = ROM_V[ORIENT_WIDTH-1:0];
  end

  // Maps 0..359 degrees onto a table index and a sign.
  function automatic logic [7:0] fold_angle(input logic [8:0] a);
    if (a <= 9'(tpu_pkg::DEG_QUARTER)) begin
      return {1'b0, a[6:0]};
    end else if (a <= 9'(tpu_pkg::DEG_HALF)) begin
      return {1'b0, 7'(9'(tpu_pkg::DEG_HALF) - a)};
    end else if (a <= 9'(tpu_pkg::DEG_3QUARTER)) begin
      return {1'b1, 7'(a - 9'(tpu_pkg::DEG_HALF))};
    end else begin
      return {1'b1, 7'(9'(tpu_pkg::DEG_FULL) - a)};
    end
  endfunction

  assign advance = !v3_r || !q_full;
  assign in_tready = advance && rst_n;
  assign push = v3_r && !q_full;
  assign push_item = item3_r;
  assign push_sin = sin3_r;
  assign push_cos = cos3_r;

  // Stage 1: bias the angle and form the floor quotient by 360.
  assign u_nxt = 17'($signed(in_item.angle_degrees)) + 17'(tpu_pkg::ANGLE_BIAS);
  assign quot_prod = 34'(u_nxt) * 34'(tpu_pkg::RECIP_360);

  // Stage 2: remainder.
  assign a_full = u1_r - 17'(q1_r) * 17'(tpu_pkg::DEG_FULL);

  // Stage 3: table reads for sine and cosine.
  always_comb begin
    b_sum = 10'(a2_r) + 10'(tpu_pkg::DEG_QUARTER);
    if (b_sum >= 10'(tpu_pkg::DEG_FULL)) begin
      b_ang = 9'(b_sum - 10'(tpu_pkg::DEG_FULL));
    end else begin
      b_ang = b_sum[8:0];
    end
    fold_s = fold_angle(a2_r);
    fold_c = fold_angle(b_ang);
    sin_nxt = fold_s[7] ? -rom_q[fold_s[6:0]] : rom_q[fold_s[6:0]];
    cos_nxt = fold_c[7] ? -rom_q[fold_c[6:0]] : rom_q[fold_c[6:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (advance) begin
      v1_r <= in_tvalid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      item1_r <= in_item;
      u1_r <= u_nxt;
      q1_r <= quot_prod[32:25];
      item2_r <= item1_r;
      a2_r <= a_full[8:0];
      item3_r <= item2_r;
      sin3_r <= sin_nxt;
      cos3_r <= cos_nxt;
    end
  end

endmodule

### sv/tpu_queue.sv
// Short first-in first-out queue between the front and back parts.
module tpu_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output logic [WIDTH-1:0] head_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [0:DEPTH-1];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign full = (count_r == CW'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

### sv/tpu_back.sv
// Back part: holds the pose, applies one command per cycle unless the output stalls, and registers the result.
module tpu_back #(
  parameter int ORIENT_WIDTH = 16,
  parameter int POS_WIDTH = 32
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  q_valid,
  input  tpu_pkg::tpu_item_t                    q_item,
  input  logic signed [ORIENT_WIDTH-1:0]        q_sin,
  input  logic signed [ORIENT_WIDTH-1:0]        q_cos,
  output logic                                  q_pop,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [tpu_pkg::OUT_DATA_W-1:0]        out_tdata
);

  localparam int OW = ORIENT_WIDTH;
  localparam int PW = POS_WIDTH;
  localparam int FRAC = OW - 2;
  localparam int RW = 2 * OW + 1;
  localparam int MPW = 32 + OW;
  localparam int MW = ((PW > MPW + 1) ? PW : MPW + 1) + 1;
  localparam int SPW = ((PW > 32) ? PW : 32) + 1;

  localparam logic signed [OW-1:0] O_ONE = {2'b01, {FRAC{1'b0}}};
  localparam logic signed [OW-1:0] O_NEG_ONE = {2'b11, {FRAC{1'b0}}};
  localparam logic signed [RW-1:0] O_HALF = {{(RW-FRAC){1'b0}}, 1'b1, {(FRAC-1){1'b0}}};
  localparam logic signed [RW-1:0] O_HI = {{(RW-OW+1){1'b0}}, {(OW-1){1'b1}}};
  localparam logic signed [RW-1:0] O_LO = {{(RW-OW+1){1'b1}}, {(OW-1){1'b0}}};
  localparam logic signed [MPW:0] M_HALF = {{(MPW-FRAC+1){1'b0}}, 1'b1, {(FRAC-1){1'b0}}};
  localparam logic signed [MW-1:0] M_HI = {{(MW-PW+1){1'b0}}, {(PW-1){1'b1}}};
  localparam logic signed [MW-1:0] M_LO = {{(MW-PW+1){1'b1}}, {(PW-1){1'b0}}};
  localparam logic signed [SPW-1:0] S_HI = {{(SPW-PW+1){1'b0}}, {(PW-1){1'b1}}};
  localparam logic signed [SPW-1:0] S_LO = {{(SPW-PW+1){1'b1}}, {(PW-1){1'b0}}};

  logic signed [PW-1:0] pos_r [0:2];
  logic signed [PW-1:0] pos_nxt [0:2];
  logic signed [OW-1:0] orient_r [0:2][0:2];
  logic signed [OW-1:0] orient_nxt [0:2][0:2];
  logic out_valid_r;
  logic [tpu_pkg::OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  logic signed [OW-1:0] opnd_v [0:2];
  logic signed [2*OW-1:0] p_cx [0:2];
  logic signed [2*OW-1:0] p_sv [0:2];
  logic signed [2*OW-1:0] p_sx [0:2];
  logic signed [2*OW-1:0] p_cv [0:2];
  logic signed [RW-1:0] rot_a [0:2];
  logic signed [RW-1:0] rot_b [0:2];
  logic signed [OW-1:0] rot_a_s [0:2];
  logic signed [OW-1:0] rot_b_s [0:2];
  logic signed [MPW-1:0] mv_prod [0:2];
  logic signed [MPW:0] mv_rnd [0:2];
  logic signed [MW-1:0] mv_sum [0:2];
  logic signed [PW-1:0] mv_sat [0:2];
  logic [31:0] set_val [0:2];
  logic signed [SPW-1:0] set_ext [0:2];
  logic signed [PW-1:0] set_sat [0:2];
  logic [63:0] wide_tmp [0:11];

  // Round to nearest (ties up) by 2^FRAC, then clamp to the orientation width.
  function automatic logic signed [OW-1:0] round_sat_rot(input logic signed [RW-1:0] v);
    logic signed [RW-1:0] t;
    t = (v + O_HALF) >>> FRAC;
    if (t > O_HI) begin
      return O_HI[OW-1:0];
    end else if (t < O_LO) begin
      return O_LO[OW-1:0];
    end else begin
      return t[OW-1:0];
    end
  endfunction

  assign q_pop = q_valid && (!out_valid_r || out_tready);
  assign out_tvalid = out_valid_r;
  assign out_tdata = out_data_r;

  // Rotation and move datapath, one lane per orientation column or axis.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      opnd_v[i] = (q_item.opcode == tpu_pkg::OP_PITCH) ? orient_r[i][2] : orient_r[i][1];
      p_cx[i] = q_cos * orient_r[i][0];
      p_sv[i] = q_sin * opnd_v[i];
      p_sx[i] = q_sin * orient_r[i][0];
      p_cv[i] = q_cos * opnd_v[i];
      if (q_item.opcode == tpu_pkg::OP_PITCH) begin
        rot_a[i] = RW'(p_cx[i]) + RW'(p_sv[i]);
        rot_b[i] = RW'(p_cv[i]) - RW'(p_sx[i]);
      end else begin
        rot_a[i] = RW'(p_cx[i]) - RW'(p_sv[i]);
        rot_b[i] = RW'(p_sx[i]) + RW'(p_cv[i]);
      end
      rot_a_s[i] = round_sat_rot(rot_a[i]);
      rot_b_s[i] = round_sat_rot(rot_b[i]);

      // Move: distance times heading component, rounded, then a clamped add.
      mv_prod[i] = $signed(q_item.distance) * orient_r[0][i];
      mv_rnd[i] = ((MPW+1)'(mv_prod[i]) + M_HALF) >>> FRAC;
      mv_sum[i] = MW'(pos_r[i]) + MW'(mv_rnd[i]);
      if (mv_sum[i] > M_HI) begin
        mv_sat[i] = M_HI[PW-1:0];
      end else if (mv_sum[i] < M_LO) begin
        mv_sat[i] = M_LO[PW-1:0];
      end else begin
        mv_sat[i] = mv_sum[i][PW-1:0];
      end
    end
  end

  // Loaded position values, clamped when the position is narrower than 32 bits.
  always_comb begin
    set_val[0] = q_item.value_x;
    set_val[1] = q_item.value_y;
    set_val[2] = q_item.value_z;
    for (int i = 0; i < 3; i++) begin
      set_ext[i] = SPW'($signed(set_val[i]));
      if (set_ext[i] > S_HI) begin
        set_sat[i] = S_HI[PW-1:0];
      end else if (set_ext[i] < S_LO) begin
        set_sat[i] = S_LO[PW-1:0];
      end else begin
        set_sat[i] = set_ext[i][PW-1:0];
      end
    end
  end

  always_comb begin
    pos_nxt = pos_r;
    orient_nxt = orient_r;
    case (q_item.opcode)
      tpu_pkg::OP_TURN: begin
        for (int i = 0; i < 3; i++) begin
          orient_nxt[i][0] = rot_a_s[i];
          orient_nxt[i][1] = rot_b_s[i];
        end
      end
      tpu_pkg::OP_PITCH: begin
        for (int i = 0; i < 3; i++) begin
          orient_nxt[i][0] = rot_a_s[i];
          orient_nxt[i][2] = rot_b_s[i];
        end
      end
      tpu_pkg::OP_MOVE: begin
        for (int i = 0; i < 3; i++) begin
          pos_nxt[i] = mv_sat[i];
        end
      end
      tpu_pkg::OP_SET_POS: begin
        for (int i = 0; i < 3; i++) begin
          pos_nxt[i] = set_sat[i];
        end
      end
      tpu_pkg::OP_SET_COL: begin
        // A select of three names no column and leaves the pose alone.
        if (q_item.column_select < tpu_pkg::NUM_COLS) begin
          for (int r = 0; r < 3; r++) begin
            orient_nxt[q_item.column_select][r] = set_val[r][OW-1:0];
          end
        end
      end
      tpu_pkg::OP_REPORT: begin
      end
      default: begin
      end
    endcase
  end

  // Result word: position first, then the orientation column by column.
  always_comb begin
    out_data_nxt = '0;
    for (int i = 0; i < 3; i++) begin
      wide_tmp[i] = 64'(pos_nxt[i]);
      out_data_nxt[32*i +: 32] = wide_tmp[i][31:0];
    end
    for (int c = 0; c < 3; c++) begin
      for (int r = 0; r < 3; r++) begin
        wide_tmp[3 + 3*c + r] = 64'(orient_nxt[c][r]);
        out_data_nxt[96 + 16*(3*c + r) +: 16] = wide_tmp[3 + 3*c + r][15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      // Home pose: heading (0,1,0), left (0,0,1), up (-1,0,0).
      for (int i = 0; i < 3; i++) begin
        pos_r[i] <= '0;
        for (int r = 0; r < 3; r++) begin
          orient_r[i][r] <= ((i == 0 && r == 1) || (i == 1 && r == 2)) ? O_ONE :
                            (i == 2 && r == 0) ? O_NEG_ONE : '0;
        end
      end
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        pos_r <= pos_nxt;
        orient_r <= orient_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

### sv/turtle_pose_update_unit.sv
// Top level of the turtle pose update unit: ports, field packing and part wiring.
//
// The unit keeps a 3D turtle pose: a position and a 3x3 orientation whose
// columns are heading, left and up. Commands arrive on the in_ stream; every
// command yields exactly one pose report on the out_ stream, in order.
// The front part biases the angle, reduces it modulo 360 and reads sine and
// cosine from a quarter-wave table in three pipeline stages. A queue of
// QUEUE_DEPTH entries decouples it from the back part, which applies one
// command per cycle, unless out_tready holds it, to the pose registers and
// loads the output register. Between an input transfer and out_tvalid lie
// the front stages, the queue and the output register; throughput is one
// command per cycle when nothing stalls; each next pose depends on the one before.
// When the receiver holds out_tready low, the result stays in the output
// register, the queue fills, the front pipeline stops and in_tready falls.
// A synchronous reset (rst_n low) restores the home pose: position zero,
// heading (0,1,0), left (0,0,1), up (-1,0,0), and empties all stages.
// in_tready is low while reset is held; no clearing pass follows reset.
module turtle_pose_update_unit #(
  parameter int ORIENT_WIDTH = 16,
  parameter int POS_WIDTH = 32,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // angle_degrees[15:0], distance[47:16], value_x[79:48], value_y[111:80],
  // value_z[143:112]
  input  logic [tpu_pkg::IN_DATA_W-1:0]      in_tdata,
  // opcode[2:0], column_select[4:3]
  input  logic [tpu_pkg::IN_USER_W-1:0]      in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // pos_x[31:0], pos_y[63:32], pos_z[95:64], heading_x/y/z[143:96],
  // left_x/y/z[191:144], up_x/y/z[239:192], 16 bits each from x up
  output logic [tpu_pkg::OUT_DATA_W-1:0]     out_tdata
);

  localparam int QW = $bits(tpu_pkg::tpu_item_t) + 2 * ORIENT_WIDTH;

  tpu_pkg::tpu_item_t in_item, push_item, head_item;
  logic push, q_full, q_pop, head_valid;
  logic signed [ORIENT_WIDTH-1:0] push_sin, push_cos, head_sin, head_cos;
  logic [QW-1:0] head_data;

  // Unpack the stream words into the command fields.
  assign in_item.opcode = in_tuser[2:0];
  assign in_item.column_select = in_tuser[4:3];
  assign in_item.angle_degrees = in_tdata[15:0];
  assign in_item.distance = in_tdata[47:16];
  assign in_item.value_x = in_tdata[79:48];
  assign in_item.value_y = in_tdata[111:80];
  assign in_item.value_z = in_tdata[143:112];

  tpu_front #(
    .ORIENT_WIDTH(ORIENT_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_item  (in_item),
    .q_full   (q_full),
    .push     (push),
    .push_item(push_item),
    .push_sin (push_sin),
    .push_cos (push_cos)
  );

  tpu_queue #(
    .WIDTH(QW),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data ({push_sin, push_cos, push_item}),
    .full      (q_full),
    .pop       (q_pop),
    .head_valid(head_valid),
    .head_data (head_data)
  );

  // Each queue entry carries the command with its sine and cosine on top.
  assign head_item = head_data[$bits(tpu_pkg::tpu_item_t)-1:0];
  assign head_cos = head_data[$bits(tpu_pkg::tpu_item_t) +: ORIENT_WIDTH];
  assign head_sin = head_data[$bits(tpu_pkg::tpu_item_t) + ORIENT_WIDTH +: ORIENT_WIDTH];

  tpu_back #(
    .ORIENT_WIDTH(ORIENT_WIDTH),
    .POS_WIDTH   (POS_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (head_valid),
    .q_item    (head_item),
    .q_sin     (head_sin),
    .q_cos     (head_cos),
    .q_pop     (q_pop),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

endmodule

### sv/tpu_checker.sv
// Port-level checks of the turtle pose update unit and their bind.
module tpu_checker #(
  parameter int MAX_INFLIGHT = 8
) (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic [tpu_pkg::IN_DATA_W-1:0]   in_tdata,
  input logic [tpu_pkg::IN_USER_W-1:0]   in_tuser,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [tpu_pkg::OUT_DATA_W-1:0]  out_tdata
);

  localparam int CW = $clog2(MAX_INFLIGHT + 1) + 1;

  logic in_xfer, out_xfer;
  logic [CW-1:0] inflight_r, inflight_nxt;

  assign in_xfer = in_tvalid && in_tready;
  assign out_xfer = out_tvalid && out_tready;
  assign inflight_nxt = inflight_r + CW'(in_xfer) - CW'(out_xfer);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inflight_r <= '0;
    end else begin
      inflight_r <= inflight_nxt;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result withdrawn while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result offered right after reset");

  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> inflight_r != '0)
    else $error("result offered with no command outstanding");

  a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    inflight_r <= CW'(MAX_INFLIGHT))
    else $error("more commands outstanding than the unit can hold");

  // Input payload is watched only through the transfer count.
  logic unused_payload;
  assign unused_payload = ^{in_tdata, in_tuser};

endmodule

bind turtle_pose_update_unit tpu_checker #(
  .MAX_INFLIGHT(QUEUE_DEPTH + 4)
) u_tpu_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .in_tdata  (in_tdata),
  .in_tuser  (in_tuser),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata)
);

### bench/tpu_pose_checker.sv
// Pose checker: watches both streams, predicts each pose report and compares it field by field.
`timescale 1ns / 100ps
module tpu_pose_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [tpu_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic [tpu_pkg::IN_USER_W-1:0]  in_tuser,
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [tpu_pkg::OUT_DATA_W-1:0] out_tdata,
  output int                             fail_count,
  output int                             reports_pending
);
  import tpu_pkg::*;

  localparam int ORIENT_W = 16;
  localparam int ORIENT_FRAC = ORIENT_W - 2;
  localparam int POS_W = 32;
  localparam int NUM_FIELDS = 12;

  logic signed [POS_W-1:0]    turtle_pos [3];
  logic signed [ORIENT_W-1:0] turtle_axes [9];
  longint                     sine_q14 [0:DEG_QUARTER];
  logic [OUT_DATA_W-1:0]      expected_reports [$];
  string field_names [NUM_FIELDS] = '{"pos_x", "pos_y", "pos_z",
                                      "heading_x", "heading_y", "heading_z",
                                      "left_x", "left_y", "left_z",
                                      "up_x", "up_y", "up_z"};

  // Round v / 2^n to nearest with ties toward plus infinity (floor after the bias).
  function automatic longint round_shift(longint v, int n);
    return (v + (longint'(1) << (n - 1))) >>> n;
  endfunction

  function automatic longint clamp_signed(longint v, int w);
    longint hi;
    longint lo;
    hi = (longint'(1) << (w - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // Fixed-point Taylor series of sin(k degrees), rounded to Q2.14.
  function automatic longint sine_entry(int k);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          s;
    int              i;
    x = longint'(k) * DEG_Q30;
    x2 = (x * x) >> 30;
    term = x;
    s = longint'(x);
    for (i = 1; i <= 6; i++) begin
      term = ((term * x2) >> 30) / longint'((2 * i) * (2 * i + 1));
      if (i % 2 == 1) s -= longint'(term);
      else s += longint'(term);
    end
    if (s < 0) s = 0;
    return round_shift(s, 30 - ORIENT_FRAC);
  endfunction

  function automatic longint sine_deg(int a);
    if (a <= DEG_QUARTER) return sine_q14[a];
    if (a <= DEG_HALF) return sine_q14[DEG_HALF - a];
    if (a <= DEG_3QUARTER) return -sine_q14[a - DEG_HALF];
    return -sine_q14[DEG_FULL - a];
  endfunction

  function automatic longint rotate_term(longint p, longint u, longint q, longint v);
    return clamp_signed(round_shift(p * u + q * v, ORIENT_FRAC), ORIENT_W);
  endfunction

  function automatic void home_pose();
    int i;
    for (i = 0; i < 3; i++) turtle_pos[i] = '0;
    for (i = 0; i < 9; i++) turtle_axes[i] = '0;
    turtle_axes[1] = 16'sd1 <<< ORIENT_FRAC;
    turtle_axes[5] = 16'sd1 <<< ORIENT_FRAC;
    turtle_axes[6] = -(16'sd1 <<< ORIENT_FRAC);
  endfunction

  // Applies one command to the predicted pose and returns the report it should produce.
  function automatic logic [OUT_DATA_W-1:0] apply_command(logic [IN_DATA_W-1:0] data,
                                                         logic [IN_USER_W-1:0] user);
    logic [2:0]          op;
    logic [1:0]          col;
    logic signed [15:0]  ang;
    logic signed [31:0]  move_dist;
    logic signed [31:0]  vals [3];
    logic [OUT_DATA_W-1:0] report;
    int                  a;
    int                  i;
    longint              s;
    longint              c;
    longint              x;
    longint              y;
    longint              z;
    longint              step;
    op = user[2:0];
    col = user[4:3];
    ang = data[15:0];
    move_dist = data[47:16];
    vals[0] = data[79:48];
    vals[1] = data[111:80];
    vals[2] = data[143:112];
    case (op)
      OP_TURN, OP_PITCH: begin
        a = ((int'(ang) % DEG_FULL) + DEG_FULL) % DEG_FULL;
        s = sine_deg(a);
        c = sine_deg((a + DEG_QUARTER) % DEG_FULL);
        for (i = 0; i < 3; i++) begin
          x = turtle_axes[3 * i];
          y = turtle_axes[3 * i + 1];
          z = turtle_axes[3 * i + 2];
          if (op == OP_TURN) begin
            turtle_axes[3 * i]     = ORIENT_W'(rotate_term(c, x, -s, y));
            turtle_axes[3 * i + 1] = ORIENT_W'(rotate_term(s, x, c, y));
          end else begin
            turtle_axes[3 * i]     = ORIENT_W'(rotate_term(c, x, s, z));
            turtle_axes[3 * i + 2] = ORIENT_W'(rotate_term(-s, x, c, z));
          end
        end
      end
      OP_MOVE: begin
        for (i = 0; i < 3; i++) begin
          step = round_shift(longint'(move_dist) * longint'(turtle_axes[i]), ORIENT_FRAC);
          turtle_pos[i] = POS_W'(clamp_signed(longint'(turtle_pos[i]) + step, POS_W));
        end
      end
      OP_SET_POS: begin
        for (i = 0; i < 3; i++) turtle_pos[i] = vals[i];
      end
      OP_SET_COL: begin
        if (col < NUM_COLS) begin
          for (i = 0; i < 3; i++) turtle_axes[3 * col + i] = vals[i][ORIENT_W-1:0];
        end
      end
      default: begin
        // Report only, including the two spare opcodes.
      end
    endcase
    for (i = 0; i < 3; i++) report[32 * i +: 32] = turtle_pos[i];
    for (i = 0; i < 9; i++) report[96 + 16 * i +: 16] = turtle_axes[i];
    return report;
  endfunction

  initial begin : build_sine
    int k;
    for (k = 0; k <= DEG_QUARTER; k++) sine_q14[k] = sine_entry(k);
    home_pose();
  end

  // Results are checked before the same edge's command is predicted, so a report
  // never gets matched against an expectation pushed in the same cycle.
  always @(posedge clk) begin : monitor
    logic [OUT_DATA_W-1:0] want;
    longint                exp_v;
    longint                got_v;
    int                    i;
    if (!rst_n) begin
      home_pose();
      expected_reports.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_reports.size() == 0) begin
          $error("pose report transfer with no command outstanding");
          fail_count++;
        end else begin
          want = expected_reports.pop_front();
          for (i = 0; i < NUM_FIELDS; i++) begin
            if (i < 3) begin
              exp_v = $signed(want[32 * i +: 32]);
              got_v = $signed(out_tdata[32 * i +: 32]);
            end else begin
              exp_v = $signed(want[96 + 16 * (i - 3) +: 16]);
              got_v = $signed(out_tdata[96 + 16 * (i - 3) +: 16]);
            end
            if (exp_v != got_v) begin
              $error("%s: expected %0d, got %0d", field_names[i], exp_v, got_v);
              fail_count++;
            end
          end
        end
      end
      if (in_tvalid && in_tready) begin
        expected_reports.push_back(apply_command(in_tdata, in_tuser));
      end
    end
    reports_pending = expected_reports.size();
  end

endmodule

### bench/tb_turtle_pose_update_unit.sv
// Testbench top for the turtle pose update unit: clock, reset, command stimulus and verdict.
`timescale 1ns / 100ps
module tb_turtle_pose_update_unit;
  import tpu_pkg::*;

  // The two opcodes outside the enum must behave as report only.
  localparam logic [2:0] OP_SPARE_LO = 3'd6;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;

  // Orientation column selects; the last one is not a column and must change nothing.
  localparam logic [1:0] COL_HEADING = 2'd0;
  localparam logic [1:0] COL_LEFT    = 2'd1;
  localparam logic [1:0] COL_UP      = 2'd2;
  localparam logic [1:0] COL_NONE    = 2'd3;

  localparam int RESET_CYCLES    = 8;
  localparam int ITEMS_PER_PHASE = 425;
  localparam int NUM_PHASES      = 4;
  // Time left after the final drain for any spurious report; ample margin.
  localparam int DRAIN_CYCLES    = 20;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  // angle_degrees[15:0], distance[47:16], value_x[79:48], value_y[111:80],
  // value_z[143:112]
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  // opcode[2:0], column_select[4:3]
  logic [IN_USER_W-1:0]  in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // pos_x/y/z[95:0], then heading, left and up columns, 16 bits per component
  logic [OUT_DATA_W-1:0] out_tdata;

  // Percent chance per cycle that the sender idles or the receiver stalls.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int fail_count;
  int reports_pending;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  turtle_pose_update_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  tpu_pose_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tuser        (in_tuser),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .fail_count      (fail_count),
    .reports_pending (reports_pending)
  );

  // The receiver decides afresh each cycle whether to take a report.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
  end

  // Presents one command and returns at the edge where its transfer happens.
  // in_tvalid stays high into the next call, so back-to-back commands need
  // no gap; an idle cycle lowers it only in a later time step.
  task automatic send_cmd(input logic [2:0] op, input logic [15:0] ang,
                          input logic [31:0] move_dist, input logic [1:0] col,
                          input logic [31:0] vx, input logic [31:0] vy,
                          input logic [31:0] vz);
    while (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {vz, vy, vx, move_dist, ang};
    in_tuser  <= {col, op};
    do @(posedge clk); while (!in_tready);
  endtask

  // Holds the sender off until every outstanding report has come back.
  // The count is sampled on the falling edge so it is settled.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (reports_pending != 0) @(negedge clk);
    @(posedge clk);
  endtask

  // Either a full random word or one whose low half is a plausible Q2.14
  // component in -1.0..1.0 under random upper bits, which set column ignores.
  function automatic logic [31:0] rand_word();
    if ($urandom_range(1, 0) == 0) return $urandom;
    return {16'($urandom), 16'($urandom_range(32768, 0) - 16384)};
  endfunction

  // One random command. The mix leans on turns, pitches and moves, since those
  // exercise the arithmetic; set commands keep the pose from drifting into
  // permanent saturation, and the rest are reports, spare opcodes and no-op
  // column selects.
  task automatic random_cmd();
    int          pick;
    logic [2:0]  op;
    logic [15:0] ang;
    logic [31:0] move_dist;
    logic [31:0] raw;
    pick = $urandom_range(99, 0);
    if (pick < 22) op = OP_TURN;
    else if (pick < 44) op = OP_PITCH;
    else if (pick < 66) op = OP_MOVE;
    else if (pick < 76) op = OP_SET_POS;
    else if (pick < 88) op = OP_SET_COL;
    else if (pick < 94) op = OP_REPORT;
    else if (pick < 97) op = OP_SPARE_LO;
    else op = OP_SPARE_HI;
    case ($urandom_range(3, 0))
      0: ang = 16'($urandom);
      1: ang = 16'(DEG_QUARTER * $urandom_range(8, 0) - DEG_FULL);
      default: ang = 16'($urandom_range(2 * DEG_FULL, 0) - DEG_FULL);
    endcase
    // Mostly short moves of up to eight units so the position stays in range.
    raw = $urandom;
    move_dist = ($urandom_range(3, 0) == 0) ? raw : {{12{raw[19]}}, raw[19:0]};
    send_cmd(op, ang, move_dist, 2'($urandom_range(3, 0)), rand_word(), rand_word(),
             rand_word());
  endtask

  initial begin : stimulus
    int phase;
    int n;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part. First the home pose as it stands after reset.
    send_cmd(OP_REPORT, '0, '0, COL_HEADING, '0, '0, '0);
    // Right angles both ways, zero, a full turn and the angle extremes.
    send_cmd(OP_TURN, 16'(DEG_QUARTER), '0, COL_HEADING, '0, '0, '0);
    send_cmd(OP_TURN, 16'(-DEG_QUARTER), '0, COL_HEADING, '0, '0, '0);
    send_cmd(OP_TURN, 16'd0, '0, COL_HEADING, '0, '0, '0);
    send_cmd(OP_TURN, 16'(DEG_FULL), '0, COL_HEADING, '0, '0, '0);
    send_cmd(OP_TURN, 16'h7FFF, '0, COL_HEADING, '0, '0, '0);
    send_cmd(OP_TURN, 16'h8000, '0, COL_HEADING, '0, '0, '0);
    send_cmd(OP_PITCH, 16'd30, '0, COL_HEADING, '0, '0, '0);
    send_cmd(OP_PITCH, 16'(-135), '0, COL_HEADING, '0, '0, '0);
    send_cmd(OP_PITCH, 16'(DEG_HALF), '0, COL_HEADING, '0, '0, '0);
    send_cmd(OP_PITCH, 16'(DEG_3QUARTER), '0, COL_HEADING, '0, '0, '0);
    // Moves: one unit, then the largest distances of both signs.
    send_cmd(OP_MOVE, '0, 32'h0001_0000, COL_HEADING, '0, '0, '0);
    send_cmd(OP_MOVE, '0, 32'h7FFF_FFFF, COL_HEADING, '0, '0, '0);
    send_cmd(OP_MOVE, '0, 32'h8000_0000, COL_HEADING, '0, '0, '0);
    // Position at its extremes, then a move that must saturate against them.
    send_cmd(OP_SET_POS, '0, '0, COL_HEADING, 32'h7FFF_FFFF, 32'h8000_0000, '0);
    send_cmd(OP_MOVE, '0, 32'h7FFF_FFFF, COL_HEADING, '0, '0, '0);
    // Column loads take only the low 16 bits; the extremes set up a rotation
    // that overflows and must saturate.
    send_cmd(OP_SET_COL, '0, '0, COL_HEADING, 32'hFFFF_7FFF, 32'h0000_8000, 32'h1234_0000);
    send_cmd(OP_SET_COL, '0, '0, COL_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_cmd(OP_SET_COL, '0, '0, COL_LEFT, 32'hAAAA_8000, 32'h5555_7FFF, 32'h0000_C000);
    send_cmd(OP_SET_COL, '0, '0, COL_UP, 32'h0000_4000, 32'hFFFF_C000, 32'h8000_7FFF);
    send_cmd(OP_TURN, 16'd45, '0, COL_HEADING, '0, '0, '0);
    send_cmd(OP_PITCH, 16'd225, '0, COL_HEADING, '0, '0, '0);
    send_cmd(OP_MOVE, '0, 32'h8000_0000, COL_HEADING, '0, '0, '0);
    // Spare opcodes and a report with every unused field set: all ignored.
    send_cmd(OP_SPARE_LO, 16'hFFFF, 32'hFFFF_FFFF, COL_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
             32'hFFFF_FFFF);
    send_cmd(OP_SPARE_HI, 16'h5A5A, 32'h1234_5678, COL_LEFT, '0, '0, '0);
    send_cmd(OP_REPORT, 16'hFFFF, 32'hFFFF_FFFF, COL_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
             32'hFFFF_FFFF);
    send_cmd(OP_SET_POS, '0, '0, COL_HEADING, '0, '0, '0);

    // Random part in four idling phases: none, a mostly idle sender, a mostly
    // stalling receiver, and light idling on both sides. Each phase starts
    // with the pipeline fully drained, so the block also restarts from empty.
    for (phase = 0; phase < NUM_PHASES; phase++) begin
      wait_drained();
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
        default: begin send_idle_pct = 8; recv_stall_pct = 8; end
      endcase
      for (n = 0; n < ITEMS_PER_PHASE; n++) random_cmd();
    end

    // Let every report come back, then give the block time to emit anything
    // spurious before the verdict.
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && reports_pending == 0) begin
      $display("** turtle_pose_update_unit: PASSED **");
    end else begin
      $display("** turtle_pose_update_unit: FAILED **");
    end
    $finish;
  end

  // Ends a run that hangs with a failure verdict.
  initial begin : watchdog
    #2_000_000;
    $display("** turtle_pose_update_unit: FAILED **");
    $finish;
  end

endmodule
